>>> src/arfcc_pkg.sv
// Package for the radio API frame receiver with checksum check.
// Holds the shared types, codes and constants; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arfcc_pkg;

  // Frame store limits
  localparam int unsigned BufferBytes = 128;  // range 16 .. 255
  localparam int unsigned DataOffset  = 15;   // range 12 .. 15
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] StartMark = 8'h7E;
  localparam logic [7:0] SumGood   = 8'hFF;

  localparam logic [7:0] AtRespTypeReset  = 8'h88;
  localparam logic [7:0] ReceiveTypeReset = 8'h90;

  // AT command characters, big-endian
  localparam logic [15:0] CmdHp = 16'h4850;
  localparam logic [15:0] CmdId = 16'h4944;
  localparam logic [15:0] CmdWr = 16'h5752;
  localparam logic [15:0] CmdAc = 16'h4143;

  typedef enum logic [1:0] {
    KindBadSum = 2'd0,
    KindAtResp = 2'd1,
    KindData   = 2'd2,
    KindOther  = 2'd3
  } frame_kind_e;

  typedef enum logic [2:0] {
    ReplyNone   = 3'd0,
    ReplySendId = 3'd1,
    ReplySendHp = 3'd2,
    ReplySendWr = 3'd3,
    ReplySendAc = 3'd4
  } reply_e;

  typedef enum logic [1:0] {
    CfgPeerAddr    = 2'd0,
    CfgAtRespType  = 2'd1,
    CfgReceiveType = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [63:0] peer_addr;
    logic [7:0]  at_type;
    logic [7:0]  rx_type;
  } cfg_t;

  // One finished frame as the parser hands it on
  typedef struct packed {
    logic        sum_good;
    logic [7:0]  ftype;
    logic [15:0] length;
    logic [63:0] address;
    logic [7:0]  data_byte;
  } frame_rec_t;

  typedef struct packed {
    frame_kind_e kind;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [15:0] at_command;
    logic [7:0]  at_status;
    reply_e      reply_code;
    logic [63:0] sender_address;
    logic        sender_match;
    logic [7:0]  first_data_byte;
  } result_t;

  function automatic reply_e reply_for(logic [15:0] cmd, logic [7:0] status);
    logic   ok;
    reply_e r;
    ok = (status == 8'd0);
    case (cmd)
      CmdHp:   r = ok ? ReplySendId : ReplySendHp;
      CmdId:   r = ok ? ReplySendWr : ReplySendId;
      CmdWr:   r = ok ? ReplySendAc : ReplySendWr;
      CmdAc:   r = ok ? ReplyNone   : ReplySendAc;
      default: r = ReplyNone;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/arfcc_front.sv
// Byte parser: tracks position, length, checksum and captured bytes of a frame.
// Depends on arfcc_pkg; pushes one record per finished frame into the queue.
`timescale 1ns / 1ps
`default_nettype none

module arfcc_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [7:0]            byte_i,
  input  wire logic                  full_i,
  output logic                       push_o,
  output arfcc_pkg::frame_rec_t      rec_o
);

  localparam logic [7:0] BufLimit = 8'(arfcc_pkg::BufferBytes);
  localparam logic [7:0] DataPos  = 8'(arfcc_pkg::DataOffset);

  logic [7:0]  pos_q, pos_d;
  logic        wait_q, wait_d;
  logic [7:0]  lhigh_q, lhigh_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  type_q, type_d;
  logic [63:0] addr_q, addr_d;
  logic [7:0]  data_q, data_d;
  logic        accept;
  logic        is_mark;
  logic        wait_eff;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    is_mark  = (byte_i == arfcc_pkg::StartMark);
    wait_eff = is_mark ? 1'b0 : wait_q;
    pos_d    = pos_q;
    wait_d   = wait_q;
    lhigh_d  = lhigh_q;
    len_d    = len_q;
    sum_d    = sum_q;
    type_d   = type_q;
    addr_d   = addr_q;
    data_d   = data_q;
    push_o   = 1'b0;
    if (accept) begin
      // a delimiter restarts the frame wherever it falls
      if (is_mark) begin
        pos_d   = '0;
        wait_d  = 1'b0;
        lhigh_d = '0;
        len_d   = '0;
        sum_d   = '0;
        type_d  = '0;
        addr_d  = '0;
        data_d  = '0;
      end
      if (!wait_eff && (pos_d < BufLimit)) begin
        if (pos_d == 8'd1) lhigh_d = byte_i;
        if (pos_d == 8'd2) len_d = {lhigh_d, byte_i};
        if (pos_d >= 8'd3) sum_d = sum_d + byte_i;
        if (pos_d == 8'd3) type_d = byte_i;
        for (int k = 0; k < 8; k++) begin
          if (pos_d == 8'(11 - k)) addr_d[8*k +: 8] = byte_i;
        end
        if (pos_d == DataPos) data_d = byte_i;
        pos_d = pos_d + 8'd1;
        if ({9'd0, pos_d} == ({1'b0, len_d} + 17'd4)) begin
          wait_d = 1'b1;
          push_o = 1'b1;
        end
      end
    end
    rec_o.sum_good  = (sum_d == arfcc_pkg::SumGood);
    rec_o.ftype     = type_d;
    rec_o.length    = len_d;
    rec_o.address   = addr_d;
    rec_o.data_byte = data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      wait_q  <= 1'b1;
      lhigh_q <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      type_q  <= '0;
      addr_q  <= '0;
      data_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      wait_q  <= wait_d;
      lhigh_q <= lhigh_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      type_q  <= type_d;
      addr_q  <= addr_d;
      data_q  <= data_d;
    end
  end

  // a finished frame always leaves the parser hunting for a delimiter
  a_done_then_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> wait_q)
    else $error("parser did not return to delimiter hunt after a frame");

endmodule

`default_nettype wire

>>> src/arfcc_queue.sv
// Short queue of finished frame records between parser and classifier.
// Depends on arfcc_pkg for the record type and depth.
`timescale 1ns / 1ps
`default_nettype none

module arfcc_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire arfcc_pkg::frame_rec_t rec_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output logic                       valid_o,
  output arfcc_pkg::frame_rec_t      rec_o
);

  localparam int unsigned Depth = arfcc_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  arfcc_pkg::frame_rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    if (pop_i)  rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("frame queue read while empty");

endmodule

`default_nettype wire

>>> src/arfcc_back.sv
// Classifier: turns a finished frame record into a result and holds it
// in the output register. Depends on arfcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arfcc_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire arfcc_pkg::cfg_t       cfg_i,
  input  wire logic                  rec_valid_i,
  input  wire arfcc_pkg::frame_rec_t rec_i,
  output logic                       pop_o,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output arfcc_pkg::result_t         res_o
);

  localparam logic [16:0] DataPos = 17'(arfcc_pkg::DataOffset);

  logic               out_valid_q, out_valid_d;
  arfcc_pkg::result_t res_q, res_d;
  logic [16:0]        ck_pos;
  logic [63:0]        addr_m;

  assign pop_o   = rec_valid_i && (!out_valid_q || ready_i);
  assign valid_o = out_valid_q;
  assign res_o   = res_q;

  always_comb begin
    // checksum byte position; drop it where it landed in the address
    ck_pos = {1'b0, rec_i.length} + 17'd3;
    addr_m = rec_i.address;
    for (int k = 0; k < 8; k++) begin
      if (ck_pos == 17'(11 - k)) addr_m[8*k +: 8] = 8'd0;
    end

    res_d              = '0;
    res_d.frame_length = rec_i.length;
    if (!rec_i.sum_good) begin
      res_d.kind = arfcc_pkg::KindBadSum;
    end else begin
      res_d.frame_type = rec_i.ftype;
      if (rec_i.ftype == cfg_i.at_type) begin
        res_d.kind       = arfcc_pkg::KindAtResp;
        res_d.at_command = rec_i.address[55:40];
        res_d.at_status  = rec_i.address[39:32];
        res_d.reply_code = arfcc_pkg::reply_for(rec_i.address[55:40],
                                                rec_i.address[39:32]);
      end else if (rec_i.ftype == cfg_i.rx_type) begin
        res_d.kind            = arfcc_pkg::KindData;
        res_d.sender_address  = addr_m;
        res_d.sender_match    = (addr_m == cfg_i.peer_addr);
        res_d.first_data_byte = (DataPos < ck_pos) ? rec_i.data_byte : 8'd0;
      end else begin
        res_d.kind = arfcc_pkg::KindOther;
      end
    end

    out_valid_d = out_valid_q;
    if (pop_o) out_valid_d = 1'b1;
    else if (ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

  a_bad_sum_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind == arfcc_pkg::KindBadSum) |->
      (res_q.frame_type == 8'd0 && res_q.sender_address == 64'd0 &&
       res_q.reply_code == arfcc_pkg::ReplyNone))
    else $error("bad checksum result carries non-zero fields");

endmodule

`default_nettype wire

>>> src/api_frame_receiver_checksum_check_top.sv
// Top level of the radio API frame receiver with checksum check.
// Depends on arfcc_pkg, arfcc_front, arfcc_queue and arfcc_back.
//
// Usage:
//   Received serial bytes enter on the s_axis channel, one byte per transfer.
//   A 0x7E byte starts a frame; bytes 1 and 2 give the length L; the frame
//   ends when L+4 bytes have been taken, and one result transfer leaves on
//   m_axis: checksum verdict and frame kind in tuser, captured fields in tdata.
//   Bytes outside a frame, and frames longer than the buffer, are swallowed without a result.
//   The parser updates combinationally on each transfer and pushes a
//   finished frame into a two-entry queue on the transfer of its last
//   byte; the classifier loads the output register from the queue head,
//   and the result is transferred from that register.
//   Throughput: one byte per cycle while the queue has room, set by the
//   combinational parser update. s_axis_tready drops only when the queue
//   is full, i.e. when results pile up behind a stalled m_axis receiver;
//   the queue and output register absorb up to three finished frames.
//   Reset clears all frame state and the queue; the block then hunts for a
//   delimiter. Configuration registers return to peer 0, AT response type
//   0x88 and receive type 0x90. Write them only while the block is idle;
//   cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none

module api_frame_receiver_checksum_check_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input byte stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [7:0] frame_type, [23:8] frame_length, [39:24] at_command,
  // [47:40] at_status, [50:48] reply_code, [114:51] sender_address,
  // [115] sender_match, [123:116] first_data_byte, [127:124] zero
  output logic [127:0]      m_axis_tdata,
  output logic [1:0]        m_axis_tuser,   // [1:0] frame_kind
  // configuration write channel
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [63:0]  cfg_data_i
);

  arfcc_pkg::cfg_t       cfg_q, cfg_d;
  arfcc_pkg::frame_rec_t front_rec;
  arfcc_pkg::frame_rec_t head_rec;
  arfcc_pkg::result_t    res;
  logic                  push;
  logic                  pop;
  logic                  q_full;
  logic                  q_valid;

  // Configuration registers: always ready, index beyond the list is dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (arfcc_pkg::cfg_index_e'(cfg_index_i))
        arfcc_pkg::CfgPeerAddr:    cfg_d.peer_addr = cfg_data_i;
        arfcc_pkg::CfgAtRespType:  cfg_d.at_type   = cfg_data_i[7:0];
        arfcc_pkg::CfgReceiveType: cfg_d.rx_type   = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peer_addr <= '0;
      cfg_q.at_type   <= arfcc_pkg::AtRespTypeReset;
      cfg_q.rx_type   <= arfcc_pkg::ReceiveTypeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: parse each byte transfer, push finished frames
  arfcc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .full_i  (q_full),
    .push_o  (push),
    .rec_o   (front_rec)
  );

  // Queue: decouple the parser from a stalled result receiver
  arfcc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (head_rec)
  );

  // Back: classify against the configuration and hold the result
  arfcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .rec_valid_i (q_valid),
    .rec_i       (head_rec),
    .pop_o       (pop),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .res_o       (res)
  );

  // Pack result fields, lowest field first
  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {4'd0,
                         res.first_data_byte,
                         res.sender_match,
                         res.sender_address,
                         res.reply_code,
                         res.at_status,
                         res.at_command,
                         res.frame_length,
                         res.frame_type};

endmodule

`default_nettype wire

>>> test/testbench.sv
// Testbench for api_frame_receiver_checksum_check_top: self-checking, no files read.
// Needs arfcc_pkg and the RTL under src; a frame predictor checks every result.
`timescale 1ns / 1ps

module testbench;
  import arfcc_pkg::*;

  typedef enum {ShapeAt, ShapeData, ShapePlain} frame_shape_e;

  // Bytes before the first delimiter, an empty frame, an HP response with status OK,
  // then a frame cut short by a delimiter and a one-byte data frame.
  localparam logic [7:0] OpeningBytes [25] = '{
    8'h00, 8'hFF, 8'h55,
    8'h7E, 8'h00, 8'h00, 8'hFF,
    8'h7E, 8'h00, 8'h05, 8'h88, 8'h01, 8'h48, 8'h50, 8'h00, 8'hDE,
    8'h7E, 8'h00, 8'h05, 8'h90,
    8'h7E, 8'h00, 8'h01, 8'h90, 8'h6F
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = CfgPeerAddr;
  logic [63:0]  cfg_data_i = '0;

  api_frame_receiver_checksum_check_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Register copies, kept in step with the configuration transfers
  logic [63:0] peer_reg    = '0;
  logic [7:0]  at_type_reg = AtRespTypeReset;
  logic [7:0]  rx_type_reg = ReceiveTypeReset;

  // Parser state as the predictor sees it
  logic [7:0]  rx_pos     = '0;
  logic        hunting    = 1'b1;
  logic [7:0]  rx_len_hi  = '0;
  logic [15:0] rx_len     = '0;
  logic [7:0]  rx_sum     = '0;
  logic [7:0]  rx_type    = '0;
  logic [63:0] rx_addr    = '0;
  logic [7:0]  rx_data    = '0;

  logic [7:0] rx_bytes [$];
  result_t    pending_results [$];
  result_t    head;
  int         bytes_queued = 0;
  int         bytes_taken  = 0;
  int         errors       = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;

  function automatic reply_e at_reply(logic [15:0] cmd, logic [7:0] status);
    reply_e on_ok, on_err;
    on_ok  = ReplyNone;
    on_err = ReplyNone;
    if (cmd == CmdHp) begin
      on_ok  = ReplySendId;
      on_err = ReplySendHp;
    end else if (cmd == CmdId) begin
      on_ok  = ReplySendWr;
      on_err = ReplySendId;
    end else if (cmd == CmdWr) begin
      on_ok  = ReplySendAc;
      on_err = ReplySendWr;
    end else if (cmd == CmdAc) begin
      on_err = ReplySendAc;
    end
    return (status == 8'd0) ? on_ok : on_err;
  endfunction

  // Advance the parser by one received byte; queue the result of a finished frame.
  function automatic void take_rx_byte(logic [7:0] b);
    result_t     r;
    logic [63:0] addr;
    int          ck;
    if (b == StartMark) begin
      rx_pos    = '0;
      rx_len_hi = '0;
      rx_len    = '0;
      rx_sum    = '0;
      rx_type   = '0;
      rx_addr   = '0;
      rx_data   = '0;
      hunting   = 1'b0;
    end
    if (hunting || rx_pos >= BufferBytes) return;

    if (rx_pos == 8'd1) rx_len_hi = b;
    if (rx_pos == 8'd2) rx_len = {rx_len_hi, b};
    if (rx_pos >= 8'd3) rx_sum = rx_sum + b;
    if (rx_pos == 8'd3) rx_type = b;
    if (rx_pos >= 8'd4 && rx_pos <= 8'd11) rx_addr[8 * (11 - rx_pos) +: 8] = b;
    if (rx_pos == DataOffset) rx_data = b;
    rx_pos = rx_pos + 8'd1;
    if (int'(rx_pos) != int'(rx_len) + 4) return;

    hunting = 1'b1;
    r = '0;
    r.kind = KindBadSum;
    r.frame_length = rx_len;
    if (rx_sum == SumGood) begin
      r.frame_type = rx_type;
      ck = int'(rx_len) + 3;
      if (rx_type == at_type_reg) begin
        r.kind       = KindAtResp;
        r.at_command = rx_addr[55:40];
        r.at_status  = rx_addr[39:32];
        r.reply_code = at_reply(rx_addr[55:40], rx_addr[39:32]);
      end else if (rx_type == rx_type_reg) begin
        // the checksum byte does not count as address or payload
        addr = rx_addr;
        if (ck >= 4 && ck <= 11) addr[8 * (11 - ck) +: 8] = 8'h00;
        r.kind            = KindData;
        r.sender_address  = addr;
        r.sender_match    = (addr == peer_reg);
        r.first_data_byte = (DataOffset < ck) ? rx_data : 8'h00;
      end else begin
        r.kind = KindOther;
      end
    end
    pending_results.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  // Byte driver: predict on each accepted transfer, then offer the next byte or idle.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      take_rx_byte(s_axis_tdata);
      bytes_taken++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (rst_ni && rx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx_bytes.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each accepted transfer with the oldest prediction.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no frame pending: tuser %h tdata %h",
               m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        head = pending_results.pop_front();
        check_field("frame_kind", 64'(head.kind), 64'(m_axis_tuser));
        check_field("frame_type", 64'(head.frame_type), 64'(m_axis_tdata[7:0]));
        check_field("frame_length", 64'(head.frame_length), 64'(m_axis_tdata[23:8]));
        check_field("at_command", 64'(head.at_command), 64'(m_axis_tdata[39:24]));
        check_field("at_status", 64'(head.at_status), 64'(m_axis_tdata[47:40]));
        check_field("reply_code", 64'(head.reply_code), 64'(m_axis_tdata[50:48]));
        check_field("sender_address", head.sender_address, m_axis_tdata[114:51]);
        check_field("sender_match", 64'(head.sender_match), 64'(m_axis_tdata[115]));
        check_field("first_data_byte", 64'(head.first_data_byte),
                    64'(m_axis_tdata[123:116]));
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_byte(input logic [7:0] b);
    rx_bytes.push_back(b);
    bytes_queued++;
  endtask

  function automatic logic [7:0] pick_content();
    logic [7:0] v;
    v = 8'($urandom_range(255));
    // keep most delimiters out of frame bodies so that frames get to finish
    if (v == StartMark && $urandom_range(19) != 0) v = v ^ 8'h01;
    return v;
  endfunction

  // Queue one frame of length len; keep cuts it short after that many bytes.
  task automatic queue_frame(input int unsigned len, input logic [7:0] ftype,
                             input frame_shape_e shape, input bit bad_sum,
                             input int unsigned keep);
    logic [7:0]  body [];
    logic [7:0]  sum;
    logic [63:0] addr;
    logic [15:0] cmd;
    int unsigned n;
    n = (len + 1 > 140) ? 140 : len + 1;
    body = new[n];
    for (int k = 0; k < n; k++) body[k] = pick_content();
    body[0] = ftype;
    case (shape)
      ShapeAt: begin
        case ($urandom_range(4))
          0: cmd = CmdHp;
          1: cmd = CmdId;
          2: cmd = CmdWr;
          3: cmd = CmdAc;
          default: cmd = 16'($urandom_range(16'hFFFF));
        endcase
        if (n > 2) body[2] = cmd[15:8];
        if (n > 3) body[3] = cmd[7:0];
        if (n > 4) body[4] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
      end
      ShapeData: begin
        addr = $urandom_range(2) != 0 ? peer_reg : {$urandom, $urandom};
        for (int j = 0; j < 8; j++) begin
          if (j + 1 < n) body[j + 1] = addr[63 - 8 * j -: 8];
        end
      end
      default: ;
    endcase
    if (len + 1 <= n) begin
      sum = '0;
      for (int k = 0; k < len; k++) sum = sum + body[k];
      body[len] = 8'hFF - sum;
      if (bad_sum) body[len] = body[len] ^ 8'($urandom_range(1, 255));
    end
    push_byte(StartMark);
    if (keep > 1) push_byte(len[15:8]);
    if (keep > 2) push_byte(len[7:0]);
    for (int k = 0; k < n && k + 3 < keep; k++) push_byte(body[k]);
  endtask

  task automatic queue_random_frame();
    int unsigned  len, pick, keep;
    frame_shape_e shape;
    logic [7:0]   ftype;
    // line noise between frames, a stray delimiter now and then
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
    end
    pick = $urandom_range(99);
    if (pick < 65)      len = $urandom_range(16);
    else if (pick < 85) len = $urandom_range(17, 40);
    else if (pick < 91) len = $urandom_range(41, BufferBytes - 6);
    else if (pick < 94) len = BufferBytes - 4 - $urandom_range(1);
    else if (pick < 98) len = $urandom_range(BufferBytes - 3, 300);
    else                len = $urandom_range(16'hFFFF);
    pick = $urandom_range(99);
    if (pick < 40) begin
      shape = ShapeAt;
      ftype = at_type_reg;
    end else if (pick < 75) begin
      shape = ShapeData;
      ftype = rx_type_reg;
    end else begin
      shape = ShapePlain;
      ftype = 8'($urandom_range(255));
    end
    keep = ($urandom_range(99) < 5) ? $urandom_range(1, len + 3) : 32'hFFFF_FFFF;
    queue_frame(len, ftype, shape, $urandom_range(99) < 15, keep);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [63:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgPeerAddr:    peer_reg    = value;
      CfgAtRespType:  at_type_reg = value[7:0];
      CfgReceiveType: rx_type_reg = value[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] shared_type;
    int         start;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (OpeningBytes[i]) push_byte(OpeningBytes[i]);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      case (phase)
        1: write_reg(CfgPeerAddr, {$urandom, $urandom});
        2: begin
          write_reg(CfgPeerAddr, 64'hFFFF_FFFF_FFFF_FFFF);
          write_reg(CfgAtRespType, 64'h00);
          write_reg(CfgReceiveType, 64'hFF);
        end
        3: begin
          write_reg(CfgPeerAddr, 64'h0);
          write_reg(CfgAtRespType, 64'hFF);
          write_reg(CfgReceiveType, 64'h00);
        end
        4: begin
          // equal type codes: frames of that type count as AT responses
          shared_type = 8'($urandom_range(255));
          write_reg(CfgAtRespType, 64'(shared_type));
          write_reg(CfgReceiveType, 64'(shared_type));
        end
        5: begin
          write_reg(CfgPeerAddr, {$urandom, $urandom});
          write_reg(CfgAtRespType, 64'($urandom_range(255)));
          write_reg(CfgReceiveType, 64'($urandom_range(255)));
        end
        7: begin
          write_reg(CfgAtRespType, 64'(AtRespTypeReset));
          write_reg(CfgReceiveType, 64'(ReceiveTypeReset));
        end
        default: ;
      endcase
      start = bytes_queued;
      while (bytes_queued - start < 200) queue_random_frame();
      wait_drained();
    end

    repeat (12) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
